// ===== src/srt_to_affine_matrix_top_macros.svh =====
// Assertion macros shared by the srt_to_affine_matrix RTL.
`ifndef SRT_TO_AFFINE_MATRIX_TOP_MACROS_SVH
`define SRT_TO_AFFINE_MATRIX_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Implication checked on posedge clk, idle during reset.
`define SRTM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on posedge clk, idle during reset.
`define SRTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SRTM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SRTM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/srtm_pkg.sv =====
// Package: widths, constants and stage payload types of the SRT-to-matrix pipeline.
`default_nettype none

package srtm_pkg;

  localparam int Q_W     = 16;              // quaternion component, Q1.15
  localparam int SCALE_W = 16;              // scale, Q4.12
  localparam int POS_W   = 32;              // position, Q16.16
  localparam int ENT_W   = 16;              // matrix entry, Q4.12
  localparam int NUM_ENT = 9;
  localparam int NUM_AX  = 3;
  localparam int FRAC_SH = 30;              // Q.30 fraction of rotation terms

  localparam int PROD_W  = 2 * Q_W + 1;     // 2*a*b
  localparam int TERM_W  = PROD_W + 1;      // sum of two doubled products
  localparam int MUL_W   = TERM_W + SCALE_W;
  localparam int SAT_W   = MUL_W - FRAC_SH; // rounded value before clamp

  localparam logic signed [TERM_W-1:0] ONE_Q30  = TERM_W'(64'd1 << FRAC_SH);
  localparam logic signed [MUL_W-1:0]  HALF_Q30 = MUL_W'(64'd1 << (FRAC_SH - 1));
  localparam logic signed [SAT_W-1:0]  ENT_MAX  = SAT_W'(32767);
  localparam logic signed [SAT_W-1:0]  ENT_MIN  = SAT_W'(-32768);

  typedef logic [NUM_AX-1:0][POS_W-1:0] pos_t;

  typedef struct packed {
    logic [Q_W-1:0]                   qx;
    logic [Q_W-1:0]                   qy;
    logic [Q_W-1:0]                   qz;
    logic [Q_W-1:0]                   qw;
    logic [NUM_AX-1:0][SCALE_W-1:0]   scale;
    pos_t                             pos;
  } in_t;

  typedef struct packed {
    logic [PROD_W-1:0]                xx2;
    logic [PROD_W-1:0]                yy2;
    logic [PROD_W-1:0]                zz2;
    logic [PROD_W-1:0]                xy2;
    logic [PROD_W-1:0]                xz2;
    logic [PROD_W-1:0]                yz2;
    logic [PROD_W-1:0]                wx2;
    logic [PROD_W-1:0]                wy2;
    logic [PROD_W-1:0]                wz2;
    logic [NUM_AX-1:0][SCALE_W-1:0]   scale;
    pos_t                             pos;
  } prod_t;

  typedef struct packed {
    logic [NUM_ENT-1:0][TERM_W-1:0]   term;
    logic [NUM_AX-1:0][SCALE_W-1:0]   scale;
    pos_t                             pos;
  } term_t;

  typedef struct packed {
    logic [NUM_ENT-1:0][MUL_W-1:0]    prod;
    pos_t                             pos;
  } mul_t;

  typedef struct packed {
    logic [NUM_ENT-1:0][ENT_W-1:0]    m;
    pos_t                             pos;
  } mat_t;

endpackage

`default_nettype wire

// ===== src/srtm_if.sv =====
// Channel interfaces: transform input and matrix output, valid/ready.
`default_nettype none

interface srtm_in_if import srtm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [Q_W-1:0]     quat_x;
  logic signed [Q_W-1:0]     quat_y;
  logic signed [Q_W-1:0]     quat_z;
  logic signed [Q_W-1:0]     quat_w;
  logic signed [SCALE_W-1:0] scale_x;
  logic signed [SCALE_W-1:0] scale_y;
  logic signed [SCALE_W-1:0] scale_z;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic signed [POS_W-1:0]   pos_z;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w,
                  scale_x, scale_y, scale_z, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, quat_x, quat_y, quat_z, quat_w,
                scale_x, scale_y, scale_z, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface srtm_out_if import srtm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [ENT_W-1:0] m00;
  logic signed [ENT_W-1:0] m01;
  logic signed [ENT_W-1:0] m02;
  logic signed [ENT_W-1:0] m10;
  logic signed [ENT_W-1:0] m11;
  logic signed [ENT_W-1:0] m12;
  logic signed [ENT_W-1:0] m20;
  logic signed [ENT_W-1:0] m21;
  logic signed [ENT_W-1:0] m22;
  logic signed [POS_W-1:0] tx;
  logic signed [POS_W-1:0] ty;
  logic signed [POS_W-1:0] tz;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  tx, ty, tz, input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                tx, ty, tz, output ready);
endinterface

`default_nettype wire

// ===== src/srt_to_affine_matrix_top.sv =====
// Top level: rotation/scale/position transform to row-major affine matrix.
//
// Usage:
//  - in_ch takes one transform per transfer: quaternion (Q1.15), per-axis
//    scale (Q4.12) and position (Q16.16).
//  - out_ch gives one matrix per transfer: nine rotation-times-scale
//    entries in Q4.12, rounded half up and clamped, plus the position row.
//  - Four register stages: products, terms, scale multiply, round/clamp.
//    A transform is registered in each stage in that order before
//    out_ch.valid rises; with the receiver ready its matrix then transfers.
//  - Throughput is one transfer per cycle while the receiver is ready; each
//    stage holds one item and the 34x16 scale multiply in stage 3 sets the cycle time.
//  - Each stage has its own valid bit and takes a new item when it is
//    empty or its successor is taking its item, so bubbles close up.
//  - When the receiver stalls the output register holds its matrix and
//    the stall backs up stage by stage; nothing is dropped or repeated.
//    in_ch.ready falls only once every stage holds an item.
//  - Synchronous active-low reset empties all stages; payload registers
//    are not reset.
`default_nettype none
`include "srt_to_affine_matrix_top_macros.svh"

module srt_to_affine_matrix_top import srtm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srtm_in_if.sink    in_ch,
  srtm_out_if.source out_ch
);

  // stage handshakes
  logic  s1_valid, s1_ready;
  logic  s2_valid, s2_ready;
  logic  s3_valid, s3_ready;
  logic  s4_valid;

  in_t   in_data;
  prod_t s1_data;
  term_t s2_data;
  mul_t  s3_data;
  mat_t  s4_data;

  // input payload into the stage struct
  assign in_data.qx       = in_ch.quat_x;
  assign in_data.qy       = in_ch.quat_y;
  assign in_data.qz       = in_ch.quat_z;
  assign in_data.qw       = in_ch.quat_w;
  assign in_data.scale[0] = in_ch.scale_x;
  assign in_data.scale[1] = in_ch.scale_y;
  assign in_data.scale[2] = in_ch.scale_z;
  assign in_data.pos[0]   = in_ch.pos_x;
  assign in_data.pos[1]   = in_ch.pos_y;
  assign in_data.pos[2]   = in_ch.pos_z;

  srtm_prod u_prod (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (in_data),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  srtm_term u_term (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  srtm_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // last stage is the output register
  srtm_sat u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (s4_valid),
    .dn_ready (out_ch.ready),
    .dn_data  (s4_data)
  );

  assign out_ch.valid = s4_valid;
  assign out_ch.m00   = s4_data.m[0];
  assign out_ch.m01   = s4_data.m[1];
  assign out_ch.m02   = s4_data.m[2];
  assign out_ch.m10   = s4_data.m[3];
  assign out_ch.m11   = s4_data.m[4];
  assign out_ch.m12   = s4_data.m[5];
  assign out_ch.m20   = s4_data.m[6];
  assign out_ch.m21   = s4_data.m[7];
  assign out_ch.m22   = s4_data.m[8];
  assign out_ch.tx    = s4_data.pos[0];
  assign out_ch.ty    = s4_data.pos[1];
  assign out_ch.tz    = s4_data.pos[2];

  // a free output end means the whole chain can take a transfer
  `SRTM_ASSERT_IMPL(a_ready_chain, out_ch.ready || !out_ch.valid, in_ch.ready,
                    "input not ready although output side is free")
  // a new result can only come from a filled stage 3
  `SRTM_ASSERT_IMPL(a_out_from_s3, out_ch.valid && !$past(out_ch.valid),
                    $past(s3_valid), "output valid without an item in stage 3")
  // a stalled output keeps the item behind it in place
  `SRTM_ASSERT_NEXT(a_s3_hold, s4_valid && !out_ch.ready && s3_valid, s3_valid,
                    "stage 3 item lost during output stall")

endmodule

`default_nettype wire

// ===== src/srtm_prod.sv =====
// Stage 1: doubled quaternion component products.
`default_nettype none

module srtm_prod import srtm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire in_t   up_data,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output prod_t      dn_data
);

  logic  valid_r;
  prod_t data_r;
  prod_t data_nxt;

  function automatic logic [PROD_W-1:0] dprod(input logic [Q_W-1:0] a,
                                               input logic [Q_W-1:0] b);
    logic signed [2*Q_W-1:0] p;
    p = $signed(a) * $signed(b);
    return {p, 1'b0};
  endfunction

  always_comb begin
    data_nxt.xx2   = dprod(up_data.qx, up_data.qx);
    data_nxt.yy2   = dprod(up_data.qy, up_data.qy);
    data_nxt.zz2   = dprod(up_data.qz, up_data.qz);
    data_nxt.xy2   = dprod(up_data.qx, up_data.qy);
    data_nxt.xz2   = dprod(up_data.qx, up_data.qz);
    data_nxt.yz2   = dprod(up_data.qy, up_data.qz);
    data_nxt.wx2   = dprod(up_data.qw, up_data.qx);
    data_nxt.wy2   = dprod(up_data.qw, up_data.qy);
    data_nxt.wz2   = dprod(up_data.qw, up_data.qz);
    data_nxt.scale = up_data.scale;
    data_nxt.pos   = up_data.pos;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/srtm_term.sv =====
// Stage 2: rotation matrix terms in Q.30.
`default_nettype none

module srtm_term import srtm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire prod_t up_data,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output term_t      dn_data
);

  logic  valid_r;
  term_t data_r;
  term_t data_nxt;

  function automatic logic signed [TERM_W-1:0] ext(input logic [PROD_W-1:0] v);
    return $signed({v[PROD_W-1], v});
  endfunction

  always_comb begin
    data_nxt.term[0] = ONE_Q30 - (ext(up_data.yy2) + ext(up_data.zz2));
    data_nxt.term[1] = ext(up_data.xy2) + ext(up_data.wz2);
    data_nxt.term[2] = ext(up_data.xz2) - ext(up_data.wy2);
    data_nxt.term[3] = ext(up_data.xy2) - ext(up_data.wz2);
    data_nxt.term[4] = ONE_Q30 - (ext(up_data.xx2) + ext(up_data.zz2));
    data_nxt.term[5] = ext(up_data.yz2) + ext(up_data.wx2);
    data_nxt.term[6] = ext(up_data.xz2) + ext(up_data.wy2);
    data_nxt.term[7] = ext(up_data.yz2) - ext(up_data.wx2);
    data_nxt.term[8] = ONE_Q30 - (ext(up_data.xx2) + ext(up_data.yy2));
    data_nxt.scale   = up_data.scale;
    data_nxt.pos     = up_data.pos;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/srtm_mul.sv =====
// Stage 3: each rotation term times the scale of its row.
`default_nettype none

module srtm_mul import srtm_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  up_valid,
  output logic       up_ready,
  input  wire term_t up_data,
  output logic       dn_valid,
  input  wire logic  dn_ready,
  output mul_t       dn_data
);

  logic valid_r;
  mul_t data_r;
  mul_t data_nxt;

  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) begin
      data_nxt.prod[i] = MUL_W'($signed(up_data.term[i]) *
                                $signed(up_data.scale[i / NUM_AX]));
    end
    data_nxt.pos = up_data.pos;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== src/srtm_sat.sv =====
// Stage 4: round to Q4.12 (halves up), clamp, output register.
`default_nettype none

module srtm_sat import srtm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic up_valid,
  output logic      up_ready,
  input  wire mul_t up_data,
  output logic      dn_valid,
  input  wire logic dn_ready,
  output mat_t      dn_data
);

  logic valid_r;
  mat_t data_r;
  mat_t data_nxt;
  logic signed [MUL_W-1:0] rsum [NUM_ENT];
  logic signed [SAT_W-1:0] rq   [NUM_ENT];

  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) begin
      rsum[i] = $signed(up_data.prod[i]) + HALF_Q30;
      // floor division by 2^30 is the upper slice
      rq[i] = $signed(rsum[i][MUL_W-1:FRAC_SH]);
      if (rq[i] > ENT_MAX) begin
        data_nxt.m[i] = ENT_MAX[ENT_W-1:0];
      end else if (rq[i] < ENT_MIN) begin
        data_nxt.m[i] = ENT_MIN[ENT_W-1:0];
      end else begin
        data_nxt.m[i] = rq[i][ENT_W-1:0];
      end
    end
    data_nxt.pos = up_data.pos;
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire
